[sv/tsc_pkg.sv]
// Package for the transaction structure checker.
// Holds record kinds, error codes, sequencer states, register indices, compact-size and saturating-add helpers.
// No dependencies.
package tsc_pkg;

  typedef enum logic [1:0] {
    FUNC_INPUT  = 2'd0,
    FUNC_OUTPUT = 2'd1,
    FUNC_END    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ERR_OK          = 4'd0,
    ERR_LIMITS      = 4'd1,
    ERR_NO_INPUTS   = 4'd2,
    ERR_NO_OUTPUTS  = 4'd3,
    ERR_MANY_INPUTS = 4'd4,
    ERR_MANY_OUTPUTS= 4'd5,
    ERR_MALFORMED   = 4'd6,
    ERR_IN_SCRIPT   = 4'd7,
    ERR_DUPLICATE   = 4'd8,
    ERR_NEGATIVE    = 4'd9,
    ERR_OVER_MAX    = 4'd10,
    ERR_OUT_SCRIPT  = 4'd11,
    ERR_TOTAL_OVF   = 4'd12,
    ERR_TOTAL_MAX   = 4'd13,
    ERR_OVERSIZED   = 4'd14
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INPUT,
    ST_OUTPUT,
    ST_END,
    ST_EMIT
  } state_t;

  localparam logic [2:0] REG_MAX_MONEY  = 3'd0;
  localparam logic [2:0] REG_MAX_SIZE   = 3'd1;
  localparam logic [2:0] REG_MAX_INPUTS = 3'd2;
  localparam logic [2:0] REG_MAX_OUTS   = 3'd3;
  localparam logic [2:0] REG_MAX_SCRIPT = 3'd4;

  // Compact-size length of a value.
  function automatic logic [3:0] compact_len(input logic [63:0] v);
    if (v < 64'd253) begin
      compact_len = 4'd1;
    end else if (v <= 64'hFFFF) begin
      compact_len = 4'd3;
    end else if (v <= 64'hFFFF_FFFF) begin
      compact_len = 4'd5;
    end else begin
      compact_len = 4'd9;
    end
  endfunction

  // Saturating 64-bit add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? '1 : s[63:0];
  endfunction

endpackage

[sv/transaction_structure_checker.sv]
// Top level of the transaction structure checker.
// Depends on tsc_pkg and tsc_outpoint_store.
//
// Usage: transactions arrive as records on the in_ channel (func 0 input,
// 1 output, 2 end). Only an end record produces a result on the out_
// channel: error code, serialized size and record counts.
// Configuration registers are written on the cfg_ channel; the user is bound to
// write them only while idle, the block itself does not enforce it.
// Sequencing: an input record passes through the scan and input states. Each
// stored earlier outpoint is read from the store memory through its single
// read port and compared, one entry a cycle; a duplicate ends the scan early.
// An output record passes through the output state, an end record through the
// end state to the emit state, where it waits for the receiver. in_ready is
// low while a record is in work or a result waits.
// Reset: synchronous active-low rst_n restores the register defaults and
// clears all per-transaction state; the store needs no clearing since only
// entries written in the current transaction are read.
// Stall: a result is held on out_ with out_valid high until out_ready.
module transaction_structure_checker #(
  parameter int MAX_STORED_INPUTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_txid_word0,
  input  logic [63:0] in_txid_word1,
  input  logic [63:0] in_txid_word2,
  input  logic [63:0] in_txid_word3,
  input  logic [31:0] in_out_index,
  input  logic [31:0] in_script_len,
  input  logic signed [63:0] in_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_error_code,
  output logic [63:0] out_tx_size,
  output logic [15:0] out_input_total,
  output logic [15:0] out_output_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = (MAX_STORED_INPUTS > 1) ? $clog2(MAX_STORED_INPUTS) : 1;
  localparam int PW = $clog2(MAX_STORED_INPUTS + 1);
  localparam logic [PW-1:0] STORE_DEPTH = PW'(MAX_STORED_INPUTS);

  tsc_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [63:0] max_money_r;
  logic [31:0] max_size_r;
  logic [8:0]  max_inputs_r;
  logic [15:0] max_outputs_r;
  logic [31:0] max_script_r;

  // Captured record.
  logic [287:0] op_r;
  logic [31:0]  slen_r;
  logic signed [63:0] amount_r;
  logic [31:0]  script_lim_r;
  logic signed [63:0] money_lim_r;

  // Per-transaction state.
  logic [15:0] in_cnt_r, out_cnt_r;
  logic        in_over_r, out_over_r;
  logic [63:0] size_r;
  logic signed [63:0] total_r;
  logic        in_err_valid_r;
  logic [PW-1:0] in_err_pos_r;
  logic [3:0]  in_err_kind_r, out_err_kind_r;

  // Scan sequencer.
  logic [PW-1:0] scan_r;
  logic [PW-1:0] scan_lim_r;
  logic          rd_pend_r;
  logic          dup_found_r;

  logic [287:0] rd_data;
  logic         wr_en;
  logic [AW-1:0] rd_addr;

  // Result register.
  logic [3:0]  res_err_r;
  logic [63:0] res_size_r;

  logic accept;
  assign accept = in_valid && in_ready;
  assign in_ready  = (state_r == tsc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == tsc_pkg::ST_EMIT);

  assign out_error_code      = res_err_r;
  assign out_tx_size         = res_size_r;
  assign out_input_total     = in_cnt_r;
  assign out_output_total    = out_cnt_r;

  // Position of the current input, narrowed to the store range.
  logic [PW-1:0] pos_clip;
  assign pos_clip = (in_cnt_r >= 16'(MAX_STORED_INPUTS)) ? STORE_DEPTH : PW'(in_cnt_r);

  assign rd_addr = scan_r[AW-1:0];
  assign wr_en   = (state_r == tsc_pkg::ST_INPUT) && (pos_clip < STORE_DEPTH);

  tsc_outpoint_store #(.DEPTH(MAX_STORED_INPUTS), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_clip[AW-1:0]),
    .wr_data (op_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            tsc_pkg::FUNC_INPUT:  state_nxt = tsc_pkg::ST_SCAN;
            tsc_pkg::FUNC_OUTPUT: state_nxt = tsc_pkg::ST_OUTPUT;
            tsc_pkg::FUNC_END:    state_nxt = tsc_pkg::ST_END;
            default:              state_nxt = tsc_pkg::ST_IDLE;
          endcase
        end
      end
      tsc_pkg::ST_SCAN: begin
        if (!rd_pend_r && (dup_found_r || scan_r >= scan_lim_r)) begin
          state_nxt = tsc_pkg::ST_INPUT;
        end
      end
      tsc_pkg::ST_INPUT:  state_nxt = tsc_pkg::ST_IDLE;
      tsc_pkg::ST_OUTPUT: state_nxt = tsc_pkg::ST_IDLE;
      tsc_pkg::ST_END:    state_nxt = tsc_pkg::ST_EMIT;
      tsc_pkg::ST_EMIT: begin
        if (out_ready) begin
          state_nxt = tsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsc_pkg::ST_IDLE;
    endcase
  end

  // Record checks, computed from the captured record.
  logic [63:0] slen64;
  logic [63:0] in_part, out_part;
  logic        malformed, in_big;
  assign slen64    = {32'd0, slen_r};
  assign in_part   = 64'd40 + 64'(tsc_pkg::compact_len(slen64)) + slen64;
  assign out_part  = 64'd8 + 64'(tsc_pkg::compact_len(slen64)) + slen64;
  assign malformed = (op_r[287:32] == '0) && (op_r[31:0] != 32'hFFFF_FFFF);
  assign in_big    = slen_r > script_lim_r;

  // Output value checks: one compare chain on the shared adder.
  logic signed [64:0] sum_wide;
  logic [3:0] out_kind;
  assign sum_wide = {total_r[63], total_r} + {amount_r[63], amount_r};
  always_comb begin
    out_kind = tsc_pkg::ERR_OK;
    if (amount_r < 0) begin
      out_kind = tsc_pkg::ERR_NEGATIVE;
    end else if (amount_r > money_lim_r) begin
      out_kind = tsc_pkg::ERR_OVER_MAX;
    end else if (slen_r > script_lim_r) begin
      out_kind = tsc_pkg::ERR_OUT_SCRIPT;
    end else if (sum_wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      out_kind = tsc_pkg::ERR_TOTAL_OVF;
    end else if (sum_wide[63:0] > money_lim_r) begin
      out_kind = tsc_pkg::ERR_TOTAL_MAX;
    end
  end

  // End-of-transaction size and verdict.
  logic [63:0] end_size;
  logic [3:0]  end_err;
  assign end_size = tsc_pkg::sat_add(tsc_pkg::sat_add(tsc_pkg::sat_add(size_r, 64'd8),
                      64'(tsc_pkg::compact_len({48'd0, in_cnt_r}))),
                      64'(tsc_pkg::compact_len({48'd0, out_cnt_r})));
  always_comb begin
    if (max_money_r < 0 || max_size_r == '0) begin
      end_err = tsc_pkg::ERR_LIMITS;
    end else if (in_cnt_r == '0 && !in_over_r) begin
      end_err = tsc_pkg::ERR_NO_INPUTS;
    end else if (out_cnt_r == '0 && !out_over_r) begin
      end_err = tsc_pkg::ERR_NO_OUTPUTS;
    end else if (in_over_r || in_cnt_r > {7'd0, max_inputs_r}) begin
      end_err = tsc_pkg::ERR_MANY_INPUTS;
    end else if (out_over_r || out_cnt_r > max_outputs_r) begin
      end_err = tsc_pkg::ERR_MANY_OUTPUTS;
    end else if (in_err_valid_r) begin
      end_err = in_err_kind_r;
    end else if (out_err_kind_r != tsc_pkg::ERR_OK) begin
      end_err = out_err_kind_r;
    end else if (end_size > {32'd0, max_size_r}) begin
      end_err = tsc_pkg::ERR_OVERSIZED;
    end else begin
      end_err = tsc_pkg::ERR_OK;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_money_r   <= 64'sd2100000000000000;
      max_size_r    <= 32'd1000000;
      max_inputs_r  <= 9'd256;
      max_outputs_r <= 16'd4096;
      max_script_r  <= 32'd10000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsc_pkg::REG_MAX_MONEY:  max_money_r   <= cfg_data;
        tsc_pkg::REG_MAX_SIZE:   max_size_r    <= cfg_data[31:0];
        tsc_pkg::REG_MAX_INPUTS: max_inputs_r  <= cfg_data[8:0];
        tsc_pkg::REG_MAX_OUTS:   max_outputs_r <= cfg_data[15:0];
        tsc_pkg::REG_MAX_SCRIPT: max_script_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Record capture; registers are sampled at arrival.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= {in_txid_word3, in_txid_word2, in_txid_word1, in_txid_word0,
                       in_out_index};
      slen_r       <= in_script_len;
      amount_r     <= in_amount;
      script_lim_r <= max_script_r;
      money_lim_r  <= max_money_r;
    end
  end

  // Scan over stored outpoints, one entry a cycle with a registered read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      scan_lim_r  <= '0;
      rd_pend_r   <= 1'b0;
      dup_found_r <= 1'b0;
    end else if (accept) begin
      scan_r      <= '0;
      scan_lim_r  <= pos_clip;
      rd_pend_r   <= 1'b0;
      dup_found_r <= 1'b0;
    end else if (state_r == tsc_pkg::ST_SCAN) begin
      if (rd_pend_r && !dup_found_r && rd_data == op_r) begin
        dup_found_r <= 1'b1;
      end
      if (!dup_found_r && !(rd_pend_r && rd_data == op_r) && scan_r < scan_lim_r) begin
        scan_r    <= scan_r + 1'b1;
        rd_pend_r <= 1'b1;
      end else begin
        rd_pend_r <= 1'b0;
      end
    end
  end

  // Duplicate position is the entry read before the current scan pointer.
  logic [PW-1:0] dup_pos;
  assign dup_pos = scan_r - 1'b1;

  // Per-transaction state.
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == tsc_pkg::ST_EMIT && out_ready)) begin
      in_cnt_r       <= '0;
      out_cnt_r      <= '0;
      in_over_r      <= 1'b0;
      out_over_r     <= 1'b0;
      size_r         <= '0;
      total_r        <= '0;
      in_err_valid_r <= 1'b0;
      in_err_pos_r   <= '0;
      in_err_kind_r  <= tsc_pkg::ERR_OK;
      out_err_kind_r <= tsc_pkg::ERR_OK;
    end else begin
      case (state_r)
        tsc_pkg::ST_INPUT: begin
          // Duplicate at an earlier position takes precedence over later errors.
          if (dup_found_r && (!in_err_valid_r || dup_pos < in_err_pos_r)) begin
            in_err_valid_r <= 1'b1;
            in_err_pos_r   <= dup_pos;
            in_err_kind_r  <= tsc_pkg::ERR_DUPLICATE;
          end else if ((malformed || in_big) && !in_err_valid_r && !dup_found_r) begin
            in_err_valid_r <= 1'b1;
            in_err_pos_r   <= pos_clip;
            in_err_kind_r  <= malformed ? tsc_pkg::ERR_MALFORMED : tsc_pkg::ERR_IN_SCRIPT;
          end
          if (in_cnt_r != 16'hFFFF) begin
            in_cnt_r <= in_cnt_r + 16'd1;
          end else begin
            in_over_r <= 1'b1;
          end
          size_r <= tsc_pkg::sat_add(size_r, in_part);
        end
        tsc_pkg::ST_OUTPUT: begin
          if (out_err_kind_r == tsc_pkg::ERR_OK) begin
            out_err_kind_r <= out_kind;
            if (out_kind == tsc_pkg::ERR_OK || out_kind == tsc_pkg::ERR_TOTAL_MAX) begin
              total_r <= sum_wide[63:0];
            end
          end
          if (out_cnt_r != 16'hFFFF) begin
            out_cnt_r <= out_cnt_r + 16'd1;
          end else begin
            out_over_r <= 1'b1;
          end
          size_r <= tsc_pkg::sat_add(size_r, out_part);
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == tsc_pkg::ST_END) begin
      res_err_r  <= end_err;
      res_size_r <= end_size;
    end
  end

endmodule

[sv/tsc_outpoint_store.sv]
// Outpoint store for the transaction structure checker.
// One write port and one registered read port; depends on nothing.
module tsc_outpoint_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [287:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [287:0]  rd_data
);

  logic [287:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
